// ===== rtl/hcr_pkg.sv =====
// Shared types, widths and constants for the Harris corner response block.
// No dependencies; imported by every module of the block.
package hcr_pkg;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 12;
  localparam int RESP_W   = 57;
  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 12;
  localparam int ALPHA_W  = 15;

  // Stream and register port widths
  localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RESP_W + COL_W + ROW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RESP_W - COL_W - ROW_W;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam int DEF_MAX_WIDTH = 1024;

  // Block geometry
  localparam int BLOCK_SIDE = 3;
  localparam int LO         = (BLOCK_SIDE - 1) / 2;
  localparam int HI         = BLOCK_SIDE - 1 - LO;
  localparam int HALO       = HI + 1;
  localparam int ROWS       = BLOCK_SIDE + 2;
  localparam int SLOT_W     = $clog2(ROWS);
  localparam int NPTS       = BLOCK_SIDE * BLOCK_SIDE;
  localparam int BORDER     = BLOCK_SIDE - 1;

  // Datapath widths
  localparam int GRAD_W    = PIX_W + 1;
  localparam int PROD_W    = 2 * GRAD_W;
  localparam int ACC_W     = PROD_W + $clog2(NPTS) + 1;
  localparam int SUM_SQ_W  = 20;
  localparam int SUM_X_W   = 21;
  localparam int TR_W      = SUM_SQ_W + 1;
  localparam int AB_W      = 2 * SUM_SQ_W;
  localparam int DET_W     = AB_W + 1;
  localparam int DET_SHIFT = 16;
  localparam int AT_W      = ALPHA_W + TR_W;
  localparam int AT_H      = AT_W / 2;
  localparam int PP_W      = (AT_W - AT_H) + TR_W;

  // Register reset values
  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [ALPHA_W-1:0] RST_ALPHA_Q      = 15'd2621;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ALPHA_Q      = 2'd2
  } hcr_reg_t;

  typedef logic [PIX_W-1:0]           pix_t;
  typedef logic [ROWS-1:0][PIX_W-1:0] col_t;

  // Per-centre control that travels down the pipeline
  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] cy;
    logic             last;
    logic             border;
  } hcr_meta_t;

endpackage

// ===== rtl/hcr_line_store.sv =====
// Column-organized line store: one word per column holds all row slots.
// Read-modify-write of one word per pixel. Depends on hcr_pkg.
module hcr_line_store #(
  parameter int  MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [hcr_pkg::SLOT_W-1:0]  wr_slot,
  input  hcr_pkg::pix_t               wr_pixel,
  output hcr_pkg::col_t               col_px     // oldest row first
);
  import hcr_pkg::*;

  col_t mem [MAX_WIDTH];
  col_t rd_word_r;
  col_t merged;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= merged;
    if (rd_en) rd_word_r <= mem[rd_addr];
  end

  always_comb begin
    merged          = rd_word_r;
    merged[wr_slot] = wr_pixel;
  end

  // Oldest row sits one slot past the current one (mod ROWS)
  always_comb begin
    logic [SLOT_W:0] idx;
    for (int k = 0; k < ROWS; k++) begin
      idx = {1'b0, wr_slot} + (SLOT_W+1)'(k + 1);
      if (idx >= (SLOT_W+1)'(ROWS)) idx = idx - (SLOT_W+1)'(ROWS);
      col_px[k] = merged[idx[SLOT_W-1:0]];
    end
  end

endmodule

// ===== rtl/hcr_structure.sv =====
// 5x5 window shift register, gradients, products and 3x3 structure sums.
// Four registered stages. Depends on hcr_pkg.
module hcr_structure (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 shift_en,
  input  hcr_pkg::hcr_meta_t                   in_meta,
  input  hcr_pkg::col_t                        col_px,
  output logic        [hcr_pkg::SUM_SQ_W-1:0]  sum_a,
  output logic        [hcr_pkg::SUM_SQ_W-1:0]  sum_b,
  output logic signed [hcr_pkg::SUM_X_W-1:0]   sum_c,
  output hcr_pkg::hcr_meta_t                   out_meta
);
  import hcr_pkg::*;

  // win_r[row][col]: row 0 oldest, col 0 leftmost
  pix_t win_r [ROWS][ROWS];

  hcr_meta_t w_meta_r, g_meta_r, p_meta_r, s_meta_r;

  logic signed [GRAD_W-1:0] gx_nxt [NPTS];
  logic signed [GRAD_W-1:0] gy_nxt [NPTS];
  logic signed [GRAD_W-1:0] gx_r   [NPTS];
  logic signed [GRAD_W-1:0] gy_r   [NPTS];

  logic signed [PROD_W-1:0] sxx_nxt [NPTS];
  logic signed [PROD_W-1:0] syy_nxt [NPTS];
  logic signed [PROD_W-1:0] sxy_nxt [NPTS];
  logic signed [PROD_W-1:0] sxx_r   [NPTS];
  logic signed [PROD_W-1:0] syy_r   [NPTS];
  logic signed [PROD_W-1:0] sxy_r   [NPTS];

  logic        [SUM_SQ_W-1:0] a_nxt, b_nxt, a_r, b_r;
  logic signed [SUM_X_W-1:0]  c_nxt, c_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < ROWS - 1; c++) win_r[r][c] <= win_r[r][c+1];
        win_r[r][ROWS-1] <= col_px[r];
      end
    end
  end

  always_comb begin
    int r, c, k;
    for (int j = 0; j < BLOCK_SIDE; j++) begin
      for (int i = 0; i < BLOCK_SIDE; i++) begin
        r = HALO - LO + j;
        c = HALO - LO + i;
        k = j * BLOCK_SIDE + i;
        gx_nxt[k] = $signed({1'b0, win_r[r][c+1]}) - $signed({1'b0, win_r[r][c-1]});
        gy_nxt[k] = $signed({1'b0, win_r[r+1][c]}) - $signed({1'b0, win_r[r-1][c]});
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NPTS; k++) begin
      sxx_nxt[k] = gx_r[k] * gx_r[k];
      syy_nxt[k] = gy_r[k] * gy_r[k];
      sxy_nxt[k] = gx_r[k] * gy_r[k];
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc_a, acc_b, acc_c;
    acc_a = '0;
    acc_b = '0;
    acc_c = '0;
    for (int k = 0; k < NPTS; k++) begin
      acc_a = acc_a + ACC_W'(sxx_r[k]);
      acc_b = acc_b + ACC_W'(syy_r[k]);
      acc_c = acc_c + ACC_W'(sxy_r[k]);
    end
    a_nxt = acc_a[SUM_SQ_W-1:0];
    b_nxt = acc_b[SUM_SQ_W-1:0];
    c_nxt = acc_c[SUM_X_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_meta_r <= '0;
      g_meta_r <= '0;
      p_meta_r <= '0;
      s_meta_r <= '0;
    end else if (adv) begin
      w_meta_r <= in_meta;
      g_meta_r <= w_meta_r;
      p_meta_r <= g_meta_r;
      s_meta_r <= p_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r  <= gx_nxt;
      gy_r  <= gy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      c_r   <= c_nxt;
    end
  end

  assign sum_a    = a_r;
  assign sum_b    = b_r;
  assign sum_c    = c_r;
  assign out_meta = s_meta_r;

endmodule

// ===== rtl/hcr_response.sv =====
// Harris response (A*B - C*C)*2^16 - alpha*(A+B)^2 over three stages,
// the alpha*trace^2 product split in two partial products. Depends on hcr_pkg.
module hcr_response (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic        [hcr_pkg::ALPHA_W-1:0]  alpha,
  input  hcr_pkg::hcr_meta_t                  in_meta,
  input  logic        [hcr_pkg::SUM_SQ_W-1:0] sum_a,
  input  logic        [hcr_pkg::SUM_SQ_W-1:0] sum_b,
  input  logic signed [hcr_pkg::SUM_X_W-1:0]  sum_c,
  output logic        [hcr_pkg::RESP_W-1:0]   response,
  output hcr_pkg::hcr_meta_t                  out_meta
);
  import hcr_pkg::*;

  hcr_meta_t m_meta_r, d_meta_r, q_meta_r;

  logic        [AB_W-1:0]      ab_nxt, ab_r, cc_nxt, cc_r;
  logic signed [2*SUM_X_W-1:0] cc_full;
  logic        [TR_W-1:0]      tr_nxt, tr_r, tr2_r;
  logic signed [DET_W-1:0]     det_nxt, det_r, det2_r;
  logic        [AT_W-1:0]      at_nxt, at_r;
  logic        [PP_W-1:0]      plo_nxt, phi_nxt, plo_r, phi_r;
  logic        [RESP_W-1:0]    sub;
  logic        [RESP_W:0]      full;

  always_comb begin
    ab_nxt  = sum_a * sum_b;
    cc_full = sum_c * sum_c;
    cc_nxt  = cc_full[AB_W-1:0];
    tr_nxt  = TR_W'(sum_a) + TR_W'(sum_b);
  end

  always_comb begin
    det_nxt = $signed({1'b0, ab_r}) - $signed({1'b0, cc_r});
    at_nxt  = alpha * tr_r;
  end

  always_comb begin
    plo_nxt = at_r[AT_H-1:0] * tr2_r;
    phi_nxt = at_r[AT_W-1:AT_H] * tr2_r;
  end

  // Final subtract; the two's complement bits are the same for either sign
  always_comb begin
    sub  = RESP_W'({phi_r, {AT_H{1'b0}}}) + RESP_W'(plo_r);
    full = (RESP_W+1)'($signed({det2_r, {DET_SHIFT{1'b0}}})) - (RESP_W+1)'(sub);
    response = q_meta_r.border ? '0 : full[RESP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_meta_r <= '0;
      d_meta_r <= '0;
      q_meta_r <= '0;
    end else if (adv) begin
      m_meta_r <= in_meta;
      d_meta_r <= m_meta_r;
      q_meta_r <= d_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ab_r   <= ab_nxt;
      cc_r   <= cc_nxt;
      tr_r   <= tr_nxt;
      det_r  <= det_nxt;
      at_r   <= at_nxt;
      tr2_r  <= tr_r;
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      det2_r <= det_r;
    end
  end

  assign out_meta = q_meta_r;

endmodule

// ===== rtl/harris_corner_response_top.sv =====
// Throughput: one pixel per cycle, set by the single read-modify-write of one column
// word of the line store per pixel; the pipeline holds only while the output register
// waits and the last stage is full. Reset: counters to zero, registers to 640/480/2621;
// the line store is not cleared (entries are written before any non-border use).
module harris_corner_response_top #(
  parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hcr_pkg::IN_TDATA_W-1:0]    in_tdata,    // [7:0] pixel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hcr_pkg::OUT_TDATA_W-1:0]   out_tdata,   // [56:0] response, [66:57] center_col,
                                                         // [78:67] center_row, [79] zero
  output logic                              out_tlast,   // frame_last
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [hcr_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [hcr_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [hcr_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import hcr_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int WCMP = (EW > IMG_W_W) ? EW : IMG_W_W;

  function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] s);
    slot_step = (s == SLOT_W'(ROWS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // Configuration
  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic               cfg_wr;
  hcr_reg_t           cfg_idx;

  // Raster position
  logic [AW-1:0]     col_r, col_nxt, cur_col;
  logic [ROW_W-1:0]  row_r, row_nxt, cur_row;
  logic [SLOT_W-1:0] slot_r, slot_nxt, cur_slot;
  logic [EW-1:0]     ew, col_inc;
  logic [ROW_W-1:0]  eh;
  logic [ROW_W:0]    row_pre, row_inc;
  logic [WCMP-1:0]   iw_ext;
  logic              col_wrap;

  // Pipeline control
  logic      in_acc, adv, out_load, emit;
  hcr_meta_t meta_in, s1_meta_r, st_meta, last_meta;
  logic              s1_vld_r;
  pix_t              s1_pix_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [AW-1:0]     s1_col_r;
  logic              ls_wr;

  col_t                       col_px;
  logic        [SUM_SQ_W-1:0] sum_a, sum_b;
  logic signed [SUM_X_W-1:0]  sum_c;
  logic        [RESP_W-1:0]   response;

  logic               out_valid_r;
  logic [RESP_W-1:0]  out_resp_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic               out_last_r;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = hcr_reg_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      alpha_r <= RST_ALPHA_Q;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  img_w_r <= cfg_pwdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: img_h_r <= cfg_pwdata[IMG_H_W-1:0];
        REG_ALPHA_Q:      alpha_r <= cfg_pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DW'(img_w_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DW'(img_h_r);
      REG_ALPHA_Q:      cfg_prdata = CFG_DW'(alpha_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- effective frame size ----------------
  always_comb begin
    iw_ext = WCMP'(img_w_r);
    if (iw_ext > WCMP'(MAX_WIDTH))   ew = EW'(MAX_WIDTH);
    else if (iw_ext < WCMP'(ROWS))   ew = EW'(ROWS);
    else                             ew = EW'(img_w_r);
    eh = (img_h_r < IMG_H_W'(ROWS)) ? ROW_W'(ROWS) : img_h_r;
  end

  // ---------------- raster counters ----------------
  // Counters that fell outside a new size wrap before the pixel is placed
  always_comb begin
    col_wrap = EW'(col_r) >= ew;
    row_pre  = (ROW_W+1)'(row_r) + (ROW_W+1)'(col_wrap);
    cur_col  = col_wrap ? '0 : col_r;
    if (row_pre >= (ROW_W+1)'(eh)) begin
      cur_row  = '0;
      cur_slot = '0;
    end else begin
      cur_row  = row_pre[ROW_W-1:0];
      cur_slot = col_wrap ? slot_step(slot_r) : slot_r;
    end

    col_inc  = EW'(cur_col) + EW'(1);
    row_inc  = (ROW_W+1)'(cur_row) + (ROW_W+1)'(1);
    col_nxt  = col_inc[AW-1:0];
    row_nxt  = cur_row;
    slot_nxt = cur_slot;
    if (col_inc >= ew) begin
      col_nxt = '0;
      if (row_inc >= (ROW_W+1)'(eh)) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_inc[ROW_W-1:0];
        slot_nxt = slot_step(cur_slot);
      end
    end
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // ---------------- centre bookkeeping ----------------
  always_comb begin
    emit           = (cur_col >= AW'(HALO)) && (cur_row >= ROW_W'(HALO));
    meta_in.vld    = in_acc && emit;
    meta_in.cx     = COL_W'(cur_col - AW'(HALO));
    meta_in.cy     = cur_row - ROW_W'(HALO);
    meta_in.last   = (EW'(cur_col) == ew - EW'(1)) && (cur_row == eh - ROW_W'(1));
    meta_in.border = (cur_col < AW'(HALO + BORDER)) || (cur_row < ROW_W'(HALO + BORDER));
  end

  // Everything moves unless the output register waits and the last stage is full
  assign adv       = !out_valid_r || out_tready || !last_meta.vld;
  assign in_tready = adv;
  assign out_load  = !out_valid_r || out_tready;
  assign ls_wr     = s1_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_meta_r <= '0;
    end else if (adv) begin
      s1_vld_r  <= in_acc;
      s1_meta_r <= meta_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_tdata[PIX_W-1:0];
      s1_slot_r <= cur_slot;
      s1_col_r  <= cur_col;
    end
  end

  // ---------------- datapath ----------------
  hcr_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (cur_col),
    .wr_en    (ls_wr),
    .wr_addr  (s1_col_r),
    .wr_slot  (s1_slot_r),
    .wr_pixel (s1_pix_r),
    .col_px   (col_px)
  );

  hcr_structure u_structure (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .shift_en (ls_wr),
    .in_meta  (s1_meta_r),
    .col_px   (col_px),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .sum_c    (sum_c),
    .out_meta (st_meta)
  );

  hcr_response u_response (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .alpha    (alpha_r),
    .in_meta  (st_meta),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .sum_c    (sum_c),
    .response (response),
    .out_meta (last_meta)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= last_meta.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_resp_r <= response;
      out_col_r  <= last_meta.cx;
      out_row_r  <= last_meta.cy;
      out_last_r <= last_meta.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_row_r, out_col_r, out_resp_r};
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  // Read-modify-write never overlaps on one column word
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ls_wr) |-> (cur_col != s1_col_r))
    else $error("line store read and write hit the same column");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (EW'(col_r) < $past(ew)))
    else $error("column counter left the frame width");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (row_r < $past(eh)))
    else $error("row counter left the frame height");

  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && last_meta.vld))
    else $error("input held without output backpressure");

endmodule
